FILE: rtl/mtep_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// MIDI track event parser. No dependencies.
package mtep_pkg;

  localparam int VLQ_MAX_BYTES = 4;

  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int VLQ_W     = 28;
  localparam int VCNT_W    = 3;
  localparam int TPB_W     = 15;
  localparam int PERIOD_W  = 24;
  localparam int DELAY_W   = PERIOD_W + VLQ_W;
  localparam int KIND_W    = 3;
  localparam int CMD_W     = 2;
  localparam int PHASE_W   = 3;
  localparam int CFG_A_W   = 1;
  localparam int CFG_D_W   = 24;
  localparam int OUT_D_W   = 120;
  localparam int DIV_CNT_W = 5;

  localparam logic [CFG_A_W-1:0] REG_TICKS_PER_BEAT = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_INIT_PERIOD    = 1'd1;

  localparam logic [TPB_W-1:0]    TPB_RESET    = 15'd96;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd1;

  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [KIND_W-1:0] KIND_CHANNEL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_META      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EOT       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PREMATURE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd4;

  localparam logic [PHASE_W-1:0] PH_DELTA  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STATUS = 3'd1;
  localparam logic [PHASE_W-1:0] PH_P1     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_P2     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_MTYPE  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_MLEN   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_MDATA  = 3'd6;

  localparam logic [BYTE_W-1:0] META_TEMPO = 8'h51;
  localparam logic [BYTE_W-1:0] META_EOT   = 8'h2F;
  localparam logic [NIB_W-1:0]  TYPE_META  = 4'hF;
  localparam logic [NIB_W-1:0]  TYPE_PROG  = 4'hC;
  localparam logic [NIB_W-1:0]  TYPE_PRESS = 4'hD;

  typedef struct packed {
    logic take;         // accept the input transaction
    logic load_out;     // move pending result into output register
    logic div_start;    // launch tempo divide
    logic load_period;  // capture quotient into tick period
  } ctl_cmd_t;

  typedef struct packed {
    logic has_result;   // accepted transaction produces a result
    logic tempo_go;     // pending result closes a usable tempo meta
    logic out_free;     // output register can take a result this cycle
    logic div_done;
  } ctl_sts_t;

endpackage

FILE: rtl/mtep_div.sv
// Restoring divider, one quotient bit per cycle: 24-bit tempo by 15-bit
// ticks per beat. Depends on mtep_pkg.
module mtep_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mtep_pkg::PERIOD_W-1:0] dividend,
  input  logic [mtep_pkg::TPB_W-1:0]    divisor,
  output logic                          done,
  output logic [mtep_pkg::PERIOD_W-1:0] quotient
);

  logic                           busy_r, busy_nxt;
  logic [mtep_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mtep_pkg::TPB_W-1:0]     rem_r, rem_nxt;
  logic [mtep_pkg::PERIOD_W-1:0]  q_r, q_nxt;
  logic [mtep_pkg::TPB_W-1:0]     dvs_r, dvs_nxt;
  logic [mtep_pkg::TPB_W:0]       trial;
  logic [mtep_pkg::TPB_W:0]       diff;
  logic                           last_step;

  assign trial     = {rem_r, q_r[mtep_pkg::PERIOD_W-1]};
  assign diff      = trial - {1'b0, dvs_r};
  assign last_step = (cnt_r == mtep_pkg::DIV_CNT_W'(mtep_pkg::PERIOD_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[mtep_pkg::TPB_W-1:0];
        q_nxt   = {q_r[mtep_pkg::PERIOD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[mtep_pkg::TPB_W-1:0];
        q_nxt   = {q_r[mtep_pkg::PERIOD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (last_step) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  // done rises in the cycle after the last step, with the quotient settled
  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= busy_r && last_step && !start;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/mtep_dp.sv
// Datapath: parse state, config registers, pending result, delay multiply
// and output register. Depends on mtep_pkg and mtep_div.
module mtep_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtep_pkg::ctl_cmd_t            cmd,
  output mtep_pkg::ctl_sts_t            sts,
  input  logic [mtep_pkg::CMD_W-1:0]    in_cmd,
  input  logic [mtep_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          cfg_we,
  input  logic [mtep_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [mtep_pkg::CFG_D_W-1:0]  cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtep_pkg::KIND_W-1:0]   out_kind,
  output logic [mtep_pkg::OUT_D_W-1:0]  out_data,
  output logic                          out_last
);

  // configuration
  logic [mtep_pkg::TPB_W-1:0]    tpb_r;
  logic [mtep_pkg::PERIOD_W-1:0] init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r  <= mtep_pkg::TPB_RESET;
      init_r <= mtep_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mtep_pkg::REG_TICKS_PER_BEAT: tpb_r  <= cfg_wdata[mtep_pkg::TPB_W-1:0];
        mtep_pkg::REG_INIT_PERIOD:    init_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parse state
  logic [mtep_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [mtep_pkg::VLQ_W-1:0]    acc_r, acc_nxt;
  logic [mtep_pkg::VCNT_W-1:0]   vcnt_r, vcnt_nxt;
  logic [mtep_pkg::VLQ_W-1:0]    delta_r, delta_nxt;
  logic [mtep_pkg::NIB_W-1:0]    rtype_r, rtype_nxt;
  logic                          rvalid_r, rvalid_nxt;
  logic [mtep_pkg::NIB_W-1:0]    rchan_r, rchan_nxt;
  logic [mtep_pkg::BYTE_W-1:0]   first_r, first_nxt;
  logic [mtep_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [mtep_pkg::PERIOD_W-1:0] tempo_r, tempo_nxt;
  logic [mtep_pkg::BYTE_W-1:0]   mkind_r, mkind_nxt;
  logic [mtep_pkg::VLQ_W-1:0]    mrem_r, mrem_nxt;
  logic [mtep_pkg::VLQ_W-1:0]    mpos_r, mpos_nxt;
  logic                          ended_r, ended_nxt;

  // pending result (everything but the delay)
  logic                          res;
  logic                          p_tempo_r, p_tempo_nxt;
  logic                          p_zdel_r, p_zdel_nxt;
  logic [mtep_pkg::KIND_W-1:0]   p_kind_r, p_kind_nxt;
  logic [mtep_pkg::NIB_W-1:0]    p_type_r, p_type_nxt;
  logic [mtep_pkg::NIB_W-1:0]    p_chan_r, p_chan_nxt;
  logic [mtep_pkg::BYTE_W-1:0]   p_p1_r, p_p1_nxt;
  logic [mtep_pkg::BYTE_W-1:0]   p_p2_r, p_p2_nxt;
  logic [mtep_pkg::BYTE_W-1:0]   p_mtype_r, p_mtype_nxt;
  logic [mtep_pkg::BYTE_W-1:0]   p_mbyte_r, p_mbyte_nxt;
  logic [mtep_pkg::VLQ_W-1:0]    p_midx_r, p_midx_nxt;
  logic                          p_last_r, p_last_nxt;

  // variable-length quantity step
  logic [mtep_pkg::VLQ_W-1:0]    vlq_acc;
  logic [mtep_pkg::VCNT_W-1:0]   vlq_cnt;
  logic                          vlq_done;
  logic [mtep_pkg::KIND_W-1:0]   meta_res_kind;
  logic [mtep_pkg::VLQ_W-1:0]    mrem_dec;
  logic [mtep_pkg::VLQ_W-1:0]    mpos_inc;
  logic                          one_param;

  assign vlq_acc  = {acc_r[mtep_pkg::VLQ_W-8:0], in_byte[6:0]};
  assign vlq_cnt  = vcnt_r + 1'b1;
  assign vlq_done = !in_byte[7] ||
                    (vlq_cnt >= mtep_pkg::VCNT_W'(mtep_pkg::VLQ_MAX_BYTES));
  assign meta_res_kind = (mkind_r == mtep_pkg::META_EOT) ? mtep_pkg::KIND_EOT
                                                         : mtep_pkg::KIND_META;
  assign mrem_dec  = mrem_r - 1'b1;
  assign mpos_inc  = mpos_r + 1'b1;
  assign one_param = (rtype_r == mtep_pkg::TYPE_PROG) || (rtype_r == mtep_pkg::TYPE_PRESS);

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    vcnt_nxt   = vcnt_r;
    delta_nxt  = delta_r;
    rtype_nxt  = rtype_r;
    rvalid_nxt = rvalid_r;
    rchan_nxt  = rchan_r;
    first_nxt  = first_r;
    period_nxt = period_r;
    tempo_nxt  = tempo_r;
    mkind_nxt  = mkind_r;
    mrem_nxt   = mrem_r;
    mpos_nxt   = mpos_r;
    ended_nxt  = ended_r;
    res         = 1'b0;
    p_tempo_nxt = 1'b0;
    p_zdel_nxt  = 1'b0;
    p_kind_nxt  = mtep_pkg::KIND_CHANNEL;
    p_type_nxt  = rtype_r;
    p_chan_nxt  = rchan_r;
    p_p1_nxt    = '0;
    p_p2_nxt    = '0;
    p_mtype_nxt = '0;
    p_mbyte_nxt = '0;
    p_midx_nxt  = '0;
    p_last_nxt  = 1'b1;

    unique case (in_cmd)
      mtep_pkg::CMD_RESTART: begin
        phase_nxt  = mtep_pkg::PH_DELTA;
        acc_nxt    = '0;
        vcnt_nxt   = '0;
        delta_nxt  = '0;
        rtype_nxt  = '0;
        rvalid_nxt = 1'b0;
        rchan_nxt  = '0;
        first_nxt  = '0;
        period_nxt = init_r;
        tempo_nxt  = '0;
        mkind_nxt  = '0;
        mrem_nxt   = '0;
        mpos_nxt   = '0;
        ended_nxt  = 1'b0;
      end
      mtep_pkg::CMD_END: begin
        res        = 1'b1;
        p_kind_nxt = ended_r ? mtep_pkg::KIND_EOT : mtep_pkg::KIND_PREMATURE;
        p_type_nxt = '0;
        p_chan_nxt = '0;
        p_zdel_nxt = 1'b1;
        ended_nxt  = 1'b1;
        phase_nxt  = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::CMD_BYTE: begin
        if (!ended_r) begin
          unique case (phase_r)
            mtep_pkg::PH_DELTA: begin
              acc_nxt  = vlq_acc;
              vcnt_nxt = vlq_cnt;
              if (vlq_done) begin
                vcnt_nxt  = '0;
                delta_nxt = vlq_acc;
                acc_nxt   = '0;
                phase_nxt = mtep_pkg::PH_STATUS;
              end
            end
            mtep_pkg::PH_STATUS: begin
              if (in_byte[7]) begin
                rtype_nxt = in_byte[7:4];
                rchan_nxt = in_byte[3:0];
                if (in_byte[7:4] == mtep_pkg::TYPE_META) begin
                  rvalid_nxt = 1'b0;
                  phase_nxt  = mtep_pkg::PH_MTYPE;
                end else begin
                  rvalid_nxt = 1'b1;
                  phase_nxt  = mtep_pkg::PH_P1;
                end
              end else if (!rvalid_r) begin
                // data byte with no running status
                res        = 1'b1;
                p_kind_nxt = mtep_pkg::KIND_ERROR;
                p_type_nxt = '0;
                p_chan_nxt = '0;
                p_p1_nxt   = in_byte;
                phase_nxt  = mtep_pkg::PH_DELTA;
              end else begin
                first_nxt = in_byte;
                if (one_param) begin
                  res       = 1'b1;
                  p_p1_nxt  = in_byte;
                  phase_nxt = mtep_pkg::PH_DELTA;
                end else begin
                  phase_nxt = mtep_pkg::PH_P2;
                end
              end
            end
            mtep_pkg::PH_P1: begin
              first_nxt = in_byte;
              if (one_param) begin
                res       = 1'b1;
                p_p1_nxt  = in_byte;
                phase_nxt = mtep_pkg::PH_DELTA;
              end else begin
                phase_nxt = mtep_pkg::PH_P2;
              end
            end
            mtep_pkg::PH_P2: begin
              res       = 1'b1;
              p_p1_nxt  = first_r;
              p_p2_nxt  = in_byte;
              phase_nxt = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_MTYPE: begin
              mkind_nxt = in_byte;
              acc_nxt   = '0;
              vcnt_nxt  = '0;
              phase_nxt = mtep_pkg::PH_MLEN;
            end
            mtep_pkg::PH_MLEN: begin
              acc_nxt  = vlq_acc;
              vcnt_nxt = vlq_cnt;
              if (vlq_done) begin
                vcnt_nxt  = '0;
                mrem_nxt  = vlq_acc;
                acc_nxt   = '0;
                mpos_nxt  = '0;
                tempo_nxt = '0;
                if (vlq_acc == '0) begin
                  res         = 1'b1;
                  p_kind_nxt  = meta_res_kind;
                  p_type_nxt  = mtep_pkg::TYPE_META;
                  p_mtype_nxt = mkind_r;
                  if (mkind_r == mtep_pkg::META_EOT) ended_nxt = 1'b1;
                  phase_nxt   = mtep_pkg::PH_DELTA;
                end else begin
                  phase_nxt = mtep_pkg::PH_MDATA;
                end
              end
            end
            mtep_pkg::PH_MDATA: begin
              if (mkind_r == mtep_pkg::META_TEMPO && mpos_r < mtep_pkg::VLQ_W'(3))
                tempo_nxt = {tempo_r[mtep_pkg::PERIOD_W-9:0], in_byte};
              mpos_nxt    = mpos_inc;
              mrem_nxt    = mrem_dec;
              res         = 1'b1;
              p_kind_nxt  = meta_res_kind;
              p_type_nxt  = mtep_pkg::TYPE_META;
              p_mtype_nxt = mkind_r;
              p_mbyte_nxt = in_byte;
              p_midx_nxt  = mpos_r;
              p_last_nxt  = (mrem_dec == '0);
              if (mrem_dec == '0) begin
                p_tempo_nxt = (mkind_r == mtep_pkg::META_TEMPO) &&
                              (mpos_inc >= mtep_pkg::VLQ_W'(3)) && (tpb_r != '0);
                if (mkind_r == mtep_pkg::META_EOT) ended_nxt = 1'b1;
                phase_nxt = mtep_pkg::PH_DELTA;
              end
            end
            default: phase_nxt = mtep_pkg::PH_DELTA;
          endcase
        end
      end
      default: ;
    endcase
  end

  // divider for tempo updates
  logic                          div_done;
  logic [mtep_pkg::PERIOD_W-1:0] div_q;

  mtep_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tempo_r),
    .divisor  (tpb_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mtep_pkg::PH_DELTA;
      acc_r    <= '0;
      vcnt_r   <= '0;
      delta_r  <= '0;
      rtype_r  <= '0;
      rvalid_r <= 1'b0;
      rchan_r  <= '0;
      first_r  <= '0;
      period_r <= mtep_pkg::PERIOD_RESET;
      tempo_r  <= '0;
      mkind_r  <= '0;
      mrem_r   <= '0;
      mpos_r   <= '0;
      ended_r  <= 1'b0;
      p_tempo_r <= 1'b0;
    end else if (cmd.take) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      vcnt_r   <= vcnt_nxt;
      delta_r  <= delta_nxt;
      rtype_r  <= rtype_nxt;
      rvalid_r <= rvalid_nxt;
      rchan_r  <= rchan_nxt;
      first_r  <= first_nxt;
      period_r <= period_nxt;
      tempo_r  <= tempo_nxt;
      mkind_r  <= mkind_nxt;
      mrem_r   <= mrem_nxt;
      mpos_r   <= mpos_nxt;
      ended_r  <= ended_nxt;
      p_tempo_r <= p_tempo_nxt;
    end else if (cmd.load_period) begin
      period_r <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      p_zdel_r  <= p_zdel_nxt;
      p_kind_r  <= p_kind_nxt;
      p_type_r  <= p_type_nxt;
      p_chan_r  <= p_chan_nxt;
      p_p1_r    <= p_p1_nxt;
      p_p2_r    <= p_p2_nxt;
      p_mtype_r <= p_mtype_nxt;
      p_mbyte_r <= p_mbyte_nxt;
      p_midx_r  <= p_midx_nxt;
      p_last_r  <= p_last_nxt;
    end
  end

  // output register; delay product formed as the result is loaded
  logic                          out_valid_r;
  logic [mtep_pkg::DELAY_W-1:0]  prod;
  logic [mtep_pkg::KIND_W-1:0]   o_kind_r;
  logic [mtep_pkg::OUT_D_W-1:0]  o_data_r;
  logic                          o_last_r;

  assign prod = period_r * delta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_kind_r <= p_kind_r;
      o_last_r <= p_last_r;
      o_data_r <= {p_midx_r, p_mbyte_r, p_mtype_r,
                   (p_zdel_r ? mtep_pkg::DELAY_W'(0) : prod),
                   p_p2_r, p_p1_r, p_chan_r, p_type_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = o_kind_r;
  assign out_data  = o_data_r;
  assign out_last  = o_last_r;

  assign sts.has_result = res;
  assign sts.tempo_go   = p_tempo_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.div_done   = div_done;

endmodule

FILE: rtl/mtep_ctrl.sv
// Controller: sequences accept, result load and tempo divide.
// Depends on mtep_pkg.
module mtep_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mtep_pkg::ctl_sts_t sts,
  output mtep_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt       = state_r;
    cmd.take        = 1'b0;
    cmd.load_out    = 1'b0;
    cmd.div_start   = 1'b0;
    cmd.load_period = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && sts.has_result) state_nxt = S_MUL;
      end
      S_MUL: begin
        // wait here until the output register frees up
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.tempo_go) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.load_period = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  a_take_result_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && sts.has_result |=> state_r == S_MUL)
    else $error("result transaction did not enter multiply state");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && !sts.div_done |=> state_r == S_DIV)
    else $error("left divide state before quotient ready");

endmodule

FILE: rtl/midi_track_event_parser.sv
// Top level of the MIDI track event parser: stream ports, config port,
// controller and datapath. Depends on mtep_pkg, mtep_ctrl, mtep_dp.
//
// Takes one track byte (or an end-of-data / restart command) per transaction.
// A byte that yields no result is simply taken; after a byte that yields a
// result the controller forms the delay product (tick period times delta)
// into the output register, waiting while the previous result has not been
// taken. The last byte of a tempo meta with three or more data bytes and
// nonzero ticks per beat then adds the bit-serial divide of tempo by ticks
// per beat. Configuration is written through cfg_we/cfg_addr/cfg_wdata only
// while the block is idle, a rule for the user that the block does not enforce.
module midi_track_event_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mtep_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [mtep_pkg::CFG_D_W-1:0]  cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mtep_pkg::BYTE_W-1:0]   in_tdata,   // data_byte
  input  logic [mtep_pkg::CMD_W-1:0]    in_tuser,   // command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // event_type, channel, param_first, param_second, delay, meta_type,
  // meta_byte, meta_index
  output logic [mtep_pkg::OUT_D_W-1:0]  out_tdata,
  output logic [mtep_pkg::KIND_W-1:0]   out_tuser,  // kind
  output logic                          out_tlast   // last_of_event
);

  mtep_pkg::ctl_cmd_t cmd;
  mtep_pkg::ctl_sts_t sts;

  mtep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtep_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_cmd    (in_tuser),
    .in_byte   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
